FILE: design/rotated_rect_bounding_box_core_defines.svh
// Assertion macros
`ifndef ROTATED_RECT_BOUNDING_BOX_CORE_DEFINES_SVH
`define ROTATED_RECT_BOUNDING_BOX_CORE_DEFINES_SVH

`define RRB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define RRB_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/rrb_pkg.sv
`timescale 1ns / 1ps
package rrb_pkg;
    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int CORDIC_STEPS = 30;
    // doubled coordinates and differences
    localparam int DW = COORD_BITS + 3;
    // signed turn-32 residual angle
    localparam int ZW = 32;
    // CORDIC x/y width (Q2.30 plus guard)
    localparam int CW = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [CW-1:0] UNIT_Q30 = 33'sd1073741824;
    // product width: DW + CW
    localparam int PW = DW + CW;
    // rotated coordinate width
    localparam int RW = DW + 3;

    typedef logic signed [CW-1:0] trig_t;
    typedef logic signed [DW-1:0] dcoord_t;
    typedef logic signed [RW-1:0] rcoord_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 32'sd536870912;   1: v = 32'sd316933406;
            2: v = 32'sd167458907;   3: v = 32'sd85004756;
            4: v = 32'sd42667331;    5: v = 32'sd21354465;
            6: v = 32'sd10679838;    7: v = 32'sd5340245;
            8: v = 32'sd2670163;     9: v = 32'sd1335087;
            10: v = 32'sd667544;     11: v = 32'sd333772;
            12: v = 32'sd166886;     13: v = 32'sd83443;
            14: v = 32'sd41722;      15: v = 32'sd20861;
            16: v = 32'sd10430;      17: v = 32'sd5215;
            18: v = 32'sd2608;       19: v = 32'sd1304;
            20: v = 32'sd652;        21: v = 32'sd326;
            22: v = 32'sd163;        23: v = 32'sd81;
            24: v = 32'sd41;         25: v = 32'sd20;
            26: v = 32'sd10;         27: v = 32'sd5;
            28: v = 32'sd3;          29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round(d*s/2^30) ties away from zero, from the full product
    function automatic rcoord_t round_q30(input logic signed [PW-1:0] p);
        logic [PW-1:0] a;
        logic [PW-1:0] r;
        logic signed [PW-1:0] res;
        a = p[PW-1] ? PW'(-p) : PW'(p);
        r = (a + PW'(64'd1 << 29)) >> 30;
        res = p[PW-1] ? -$signed(r) : $signed(r);
        return RW'(res);
    endfunction
endpackage

FILE: design/rrb_cordic.sv
`timescale 1ns / 1ps
module rrb_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [rrb_pkg::CORDIC_STEPS+1:0] adv,
    input  logic [rrb_pkg::ANGLE_BITS-1:0] angle,
    output rrb_pkg::trig_t       cos_q30,
    output rrb_pkg::trig_t       sin_q30
);
    import rrb_pkg::*;
    `include "rotated_rect_bounding_box_core_defines.svh"

    localparam int N = CORDIC_STEPS;
    trig_t                 x_reg [N+1];
    trig_t                 y_reg [N+1];
    logic signed [ZW-1:0]  z_reg [N+1];
    logic [1:0]            q_reg [N+1];
    trig_t                 cos_reg, sin_reg;
    logic [31:0]           t;

    assign t = {angle, (32 - ANGLE_BITS)'(0)};

    // stage 0 loads, stage i+1 does micro-rotation i
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({2'b00, t[29:0]});
            q_reg[0] <= t[31:30];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (adv[i+1]) begin
                q_reg[i+1] <= q_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
            end
        end
    end

    trig_t xc, yc;
    always_comb begin
        xc = (x_reg[N] > UNIT_Q30) ? UNIT_Q30 : ((x_reg[N] < -UNIT_Q30) ? -UNIT_Q30 : x_reg[N]);
        yc = (y_reg[N] > UNIT_Q30) ? UNIT_Q30 : ((y_reg[N] < -UNIT_Q30) ? -UNIT_Q30 : y_reg[N]);
    end

    // quadrant fold, its own stage
    always_ff @(posedge aclk) begin
        if (adv[N+1]) begin
            case (q_reg[N])
                2'd0: begin cos_reg <= xc;  sin_reg <= yc;  end
                2'd1: begin cos_reg <= -yc; sin_reg <= xc;  end
                2'd2: begin cos_reg <= -xc; sin_reg <= -yc; end
                default: begin cos_reg <= yc; sin_reg <= -xc; end
            endcase
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

    `RRB_ASSERT(a_cos_range, aclk, aresetn, ($isunknown(cos_reg) || (cos_reg <= UNIT_Q30 && cos_reg >= -UNIT_Q30)), "cos out of range")
    `RRB_ASSERT(a_sin_range, aclk, aresetn, ($isunknown(sin_reg) || (sin_reg <= UNIT_Q30 && sin_reg >= -UNIT_Q30)), "sin out of range")
    `RRB_ASSERT(a_gain_load, aclk, aresetn, (adv[0] |=> x_reg[0] == CORDIC_GAIN), "cordic load")
endmodule

FILE: design/rotated_rect_bounding_box_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                                       | Dir
// s_       | s_valid s_ready s_rect_* s_turn_angle s_pivot_* | in
// m_       | m_valid m_ready m_box_*                      | out
// Pipeline: 37 stages (31 CORDIC stages, fold, multiply, round, corner sum, min/max,
// output).
// One transaction per cycle sustained while m_ready is held high; the 30-step CORDIC sets the depth.
// Reset clears only the stage valid bits.
// A stalled output holds its stage and every full stage behind it up to the first empty one.
module rotated_rect_bounding_box_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [rrb_pkg::COORD_BITS-1:0] s_rect_left,
    input  logic signed [rrb_pkg::COORD_BITS-1:0] s_rect_top,
    input  logic [rrb_pkg::COORD_BITS-2:0] s_rect_width,
    input  logic [rrb_pkg::COORD_BITS-2:0] s_rect_height,
    input  logic [rrb_pkg::ANGLE_BITS-1:0] s_turn_angle,
    input  logic        s_pivot_given,
    input  logic signed [rrb_pkg::COORD_BITS-1:0] s_pivot_x,
    input  logic signed [rrb_pkg::COORD_BITS-1:0] s_pivot_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [rrb_pkg::COORD_BITS-1:0] m_box_left,
    output logic signed [rrb_pkg::COORD_BITS-1:0] m_box_top,
    output logic [rrb_pkg::COORD_BITS-2:0] m_box_width,
    output logic [rrb_pkg::COORD_BITS-2:0] m_box_height
);
    import rrb_pkg::*;
    `include "rotated_rect_bounding_box_core_defines.svh"

    localparam int NC = CORDIC_STEPS + 2;  // cordic stages incl. fold
    localparam int NS = NC + 5;            // total stages
    localparam int W  = COORD_BITS;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    // stage k advances when it is empty or the stage after it advances (the last stage: on m_ready)
    always_comb begin
        adv[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) adv[k] = !v_reg[k] || adv[k+1];
    end
    // adv[k] loads stage k from stage k-1 (stage 0 from input)
    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++)
                if (adv[k]) v_reg[k] <= (k == 0) ? s_valid : v_reg[k-1 < 0 ? 0 : k-1];
        end
    end

    trig_t cs, sn;
    rrb_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .adv(adv[NC-1:0]), .angle(s_turn_angle),
        .cos_q30(cs), .sin_q30(sn)
    );

    // geometry delay line alongside the CORDIC
    dcoord_t x0_reg [NC], x1_reg [NC], y0_reg [NC], y1_reg [NC], px_reg [NC], py_reg [NC];
    dcoord_t x0n, x1n, y0n, y1n, pxn, pyn;
    always_comb begin
        x0n = dcoord_t'(s_rect_left) <<< 1;
        y0n = dcoord_t'(s_rect_top) <<< 1;
        x1n = (dcoord_t'(s_rect_left) + dcoord_t'({1'b0, s_rect_width})) <<< 1;
        y1n = (dcoord_t'(s_rect_top) + dcoord_t'({1'b0, s_rect_height})) <<< 1;
        if (s_pivot_given) begin
            pxn = dcoord_t'(s_pivot_x) <<< 1;
            pyn = dcoord_t'(s_pivot_y) <<< 1;
        end else begin
            pxn = x0n + dcoord_t'({1'b0, s_rect_width});
            pyn = y0n + dcoord_t'({1'b0, s_rect_height});
        end
    end
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x0_reg[0] <= x0n - pxn; x1_reg[0] <= x1n - pxn;
            y0_reg[0] <= y0n - pyn; y1_reg[0] <= y1n - pyn;
            px_reg[0] <= pxn;       py_reg[0] <= pyn;
        end
        for (int k = 1; k < NC; k++) begin
            if (adv[k]) begin
                x0_reg[k] <= x0_reg[k-1]; x1_reg[k] <= x1_reg[k-1];
                y0_reg[k] <= y0_reg[k-1]; y1_reg[k] <= y1_reg[k-1];
                px_reg[k] <= px_reg[k-1]; py_reg[k] <= py_reg[k-1];
            end
        end
    end

    // products: dx0c dx1c dy0s dy1s dx0s dx1s dy0c dy1c
    logic signed [PW-1:0] p_reg [8];
    dcoord_t pxm_reg, pym_reg;
    always_ff @(posedge aclk) begin
        if (adv[NC]) begin
            p_reg[0] <= x0_reg[NC-1] * cs; p_reg[1] <= x1_reg[NC-1] * cs;
            p_reg[2] <= y0_reg[NC-1] * sn; p_reg[3] <= y1_reg[NC-1] * sn;
            p_reg[4] <= x0_reg[NC-1] * sn; p_reg[5] <= x1_reg[NC-1] * sn;
            p_reg[6] <= y0_reg[NC-1] * cs; p_reg[7] <= y1_reg[NC-1] * cs;
            pxm_reg <= px_reg[NC-1]; pym_reg <= py_reg[NC-1];
        end
    end

    rcoord_t r_reg [8];
    dcoord_t pxr_reg, pyr_reg;
    always_ff @(posedge aclk) begin
        if (adv[NC+1]) begin
            for (int j = 0; j < 8; j++) r_reg[j] <= round_q30(p_reg[j]);
            pxr_reg <= pxm_reg; pyr_reg <= pym_reg;
        end
    end

    // corners: rx = xc - ys + px ; ry = xs + yc + py
    rcoord_t rx_reg [4], ry_reg [4];
    always_ff @(posedge aclk) begin
        if (adv[NC+2]) begin
            for (int k = 0; k < 4; k++) begin
                rx_reg[k] <= r_reg[k & 1] - r_reg[2 + (k >> 1)] + rcoord_t'(pxr_reg);
                ry_reg[k] <= r_reg[4 + (k & 1)] + r_reg[6 + (k >> 1)] + rcoord_t'(pyr_reg);
            end
        end
    end

    rcoord_t mnx_reg, mxx_reg, mny_reg, mxy_reg;
    rcoord_t mnx, mxx, mny, mxy;
    always_comb begin
        mnx = rx_reg[0]; mxx = rx_reg[0]; mny = ry_reg[0]; mxy = ry_reg[0];
        for (int k = 1; k < 4; k++) begin
            if (rx_reg[k] < mnx) mnx = rx_reg[k];
            if (rx_reg[k] > mxx) mxx = rx_reg[k];
            if (ry_reg[k] < mny) mny = ry_reg[k];
            if (ry_reg[k] > mxy) mxy = ry_reg[k];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv[NC+3]) begin
            mnx_reg <= mnx; mxx_reg <= mxx; mny_reg <= mny; mxy_reg <= mxy;
        end
    end

    // halve with rounding, saturate
    localparam int HW = RW + 1;
    logic signed [HW-1:0] hl, ht, hw, hh;
    localparam logic signed [HW-1:0] SMAX = HW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [HW-1:0] SMIN = -SMAX - 1;
    logic signed [W-1:0] left_next, top_next;
    logic [W-2:0] w_next, h_next;
    always_comb begin
        hl = (HW'(mnx_reg) + 1) >>> 1;
        ht = (HW'(mny_reg) + 1) >>> 1;
        hw = (HW'(mxx_reg) - HW'(mnx_reg) + 1) >>> 1;
        hh = (HW'(mxy_reg) - HW'(mny_reg) + 1) >>> 1;
        left_next = (hl > SMAX) ? W'(SMAX) : ((hl < SMIN) ? W'(SMIN) : W'(hl));
        top_next  = (ht > SMAX) ? W'(SMAX) : ((ht < SMIN) ? W'(SMIN) : W'(ht));
        w_next = (hw > SMAX) ? (W-1)'(SMAX) : (W-1)'(hw);
        h_next = (hh > SMAX) ? (W-1)'(SMAX) : (W-1)'(hh);
    end

    logic signed [W-1:0] left_reg, top_reg;
    logic [W-2:0] width_reg, height_reg;
    always_ff @(posedge aclk) begin
        if (adv[NC+4]) begin
            left_reg <= left_next; top_reg <= top_next;
            width_reg <= w_next; height_reg <= h_next;
        end
    end

    assign m_valid = v_reg[NS-1];
    assign m_box_left = left_reg;
    assign m_box_top = top_reg;
    assign m_box_width = width_reg;
    assign m_box_height = height_reg;

    `RRB_ASSERT(a_ready, aclk, aresetn, (!v_reg[NS-1] |-> s_ready), "empty output must not stall input")
    `RRB_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready |=> m_valid && $stable(m_box_left)), "stalled output changed")
    `RRB_ASSERT(a_rdy_chain, aclk, aresetn, (m_ready |-> s_ready), "ready chain broken")
endmodule
